FILE: design/tea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and the round mixing function of the TEA cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int WORD_W      = 32;
    localparam int KEY_WORDS   = 4;
    localparam int CFG_INDEX_W = 3;

    localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;

    // action codes
    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_0_IDX = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_1_IDX = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_2_IDX = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_3_IDX = 3'd3;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] tea_key_t;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
    } tea_stage_t;

    function automatic logic [WORD_W-1:0] mix(
        input logic [WORD_W-1:0] v,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

endpackage

FILE: design/tea_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_in_if
// Block channel into the cipher: action bit and the two block halves.
// ----------------------------------------------------------------------------
interface tea_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] first_word;
    logic [31:0] second_word;

    modport source (output valid, output action, output first_word,
                    output second_word, input ready);
    modport sink   (input valid, input action, input first_word,
                    input second_word, output ready);
endinterface

FILE: design/tea_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_out_if
// Result channel out of the cipher: the two halves of the processed block.
// ----------------------------------------------------------------------------
interface tea_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_first_word;
    logic [31:0] out_second_word;

    modport source (output valid, output out_first_word, output out_second_word,
                    input ready);
    modport sink   (input valid, input out_first_word, input out_second_word,
                    output ready);
endinterface

FILE: design/tea_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tea_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/tea_half_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_half_round
// One registered half round: updates one block word in either direction.
// ----------------------------------------------------------------------------
module tea_half_round #(
    parameter int ROUNDS     = 32,
    parameter int ROUND_IDX  = 0,
    parameter bit FIRST_HALF = 1'b1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  tea_pkg::tea_stage_t in_stage,
    input  tea_pkg::tea_key_t   key,
    output logic                out_valid,
    output tea_pkg::tea_stage_t out_stage
);

    // running sum is fixed per stage; only the direction picks which one
    localparam logic [tea_pkg::WORD_W-1:0] SUM_ENC =
        tea_pkg::DELTA * 32'(ROUND_IDX + 1);
    localparam logic [tea_pkg::WORD_W-1:0] SUM_DEC =
        tea_pkg::DELTA * 32'(ROUNDS - ROUND_IDX);

    logic                        valid_reg;
    logic                        valid_next;
    tea_pkg::tea_stage_t         stage_reg;
    tea_pkg::tea_stage_t         stage_next;
    logic                        decrypt;
    logic                        upd_y;
    logic [tea_pkg::WORD_W-1:0]  sum;
    logic [tea_pkg::WORD_W-1:0]  mix_val;

    always_comb
    begin
        decrypt = (in_stage.action == tea_pkg::ACT_DECRYPT);
        // encrypt: y then z; decrypt: z then y
        upd_y   = FIRST_HALF ? !decrypt : decrypt;
        sum     = decrypt ? SUM_DEC : SUM_ENC;
        if (upd_y)
        begin
            mix_val = tea_pkg::mix(in_stage.z, sum, key[0], key[1]);
        end
        else
        begin
            mix_val = tea_pkg::mix(in_stage.y, sum, key[2], key[3]);
        end

        stage_next = in_stage;
        if (upd_y)
        begin
            stage_next.y = decrypt ? in_stage.y - mix_val : in_stage.y + mix_val;
        end
        else
        begin
            stage_next.z = decrypt ? in_stage.z - mix_val : in_stage.z + mix_val;
        end
        valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

FILE: design/tea_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA encrypt/decrypt of 64-bit blocks under a 128-bit key, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+-----------------------------------------
//  blk      | in  | valid/ready | action, first_word, second_word
//  res      | out | valid/ready | out_first_word, out_second_word
//  cfg      | in  | valid/ready | index (0..3 key words), data
//
//  One item per cycle while the result is taken; one pipeline stage per
//  half round, the last stage being the output register.
//  Reset clears the stage valid bits and the key words to zero.
//  A stage holds only when it and every stage after it are full and the
//  result is not taken; bubbles close up, so blk stays ready while any
//  stage is empty. cfg is always ready.
// ----------------------------------------------------------------------------
module tea_block_cipher #(
    parameter int ROUNDS = 32
) (
    input  logic  clk,
    input  logic  rst_n,
    tea_in_if.sink    blk,
    tea_out_if.source res,
    tea_cfg_if.sink   cfg
);

    localparam int STAGES = 2 * ROUNDS;

    tea_pkg::tea_key_t   key_reg;
    tea_pkg::tea_stage_t blk_stage;
    tea_pkg::tea_stage_t stage_data [STAGES];
    logic [STAGES-1:0]   stage_valid;
    logic [STAGES-1:0]   advance;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                tea_pkg::KEY_WORD_0_IDX: key_reg[0] <= cfg.data;
                tea_pkg::KEY_WORD_1_IDX: key_reg[1] <= cfg.data;
                tea_pkg::KEY_WORD_2_IDX: key_reg[2] <= cfg.data;
                tea_pkg::KEY_WORD_3_IDX: key_reg[3] <= cfg.data;
                default: ;
            endcase
        end
    end

    // a stage moves when the result is taken or it or any later stage has a hole
    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_adv
            assign advance[s] = res.ready | ~(&stage_valid[STAGES-1:s]);
        end
    endgenerate

    assign blk.ready        = advance[0];
    assign blk_stage.action = blk.action;
    assign blk_stage.y      = blk.first_word;
    assign blk_stage.z      = blk.second_word;

    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            if (s == 0)
            begin : g_first
                tea_half_round #(
                    .ROUNDS     (ROUNDS),
                    .ROUND_IDX  (0),
                    .FIRST_HALF (1'b1)
                ) u_half (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .advance   (advance[0]),
                    .in_valid  (blk.valid),
                    .in_stage  (blk_stage),
                    .key       (key_reg),
                    .out_valid (stage_valid[0]),
                    .out_stage (stage_data[0])
                );
            end
            else
            begin : g_next
                tea_half_round #(
                    .ROUNDS     (ROUNDS),
                    .ROUND_IDX  (s / 2),
                    .FIRST_HALF ((s % 2) == 0)
                ) u_half (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .advance   (advance[s]),
                    .in_valid  (stage_valid[s-1]),
                    .in_stage  (stage_data[s-1]),
                    .key       (key_reg),
                    .out_valid (stage_valid[s]),
                    .out_stage (stage_data[s])
                );
            end
        end
    endgenerate

    assign res.valid           = stage_valid[STAGES-1];
    assign res.out_first_word  = stage_data[STAGES-1].y;
    assign res.out_second_word = stage_data[STAGES-1].z;

    // an accepted item lands in the first stage
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        blk.valid && blk.ready |=> stage_valid[0])
        else $error("accepted item missing from first stage");

    // back-pressure only when the whole pipeline is full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !blk.ready |-> (&stage_valid) && !res.ready)
        else $error("input stalled with room in the pipeline");

    // a stalled result is neither dropped nor altered
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(stage_data[STAGES-1]))
        else $error("stalled result lost or changed");

    // the first stage keeps its item while it is stalled
    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance[0] |=> stage_valid[0] && $stable(stage_data[0]))
        else $error("first stage changed while stalled");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives 64-bit blocks through the TEA cipher under a series of keys and
// compares every result block with a behavioral TEA computed in the bench or a known value.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_ROUNDS     = 32;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_BLOCKS   = 100;
    localparam int GAP_PERCENT    = 33;
    localparam int QUIET_PHASE    = 3;      // no gaps on either side
    localparam int STALL_CYCLES   = 300;
    localparam int MAX_REPORTS    = 50;

    // indexes the block must ignore
    localparam logic [tea_pkg::CFG_INDEX_W-1:0] UNUSED_IDX_LO = 3'd4;
    localparam logic [tea_pkg::CFG_INDEX_W-1:0] UNUSED_IDX_HI = 3'd7;

    typedef struct packed {
        logic                       action;
        logic [tea_pkg::WORD_W-1:0] first_word;
        logic [tea_pkg::WORD_W-1:0] second_word;
        logic                       known;
        logic [tea_pkg::WORD_W-1:0] known_first;
        logic [tea_pkg::WORD_W-1:0] known_second;
    } blk_vec_t;

    localparam int NUM_DIRECTED = 12;

    // run right after reset, key all zero
    localparam blk_vec_t DIRECTED [0:NUM_DIRECTED-1] = '{
        '{tea_pkg::ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h41ea_3a0a,
          32'h94ba_a940},
        '{tea_pkg::ACT_DECRYPT, 32'h41ea_3a0a, 32'h94ba_a940, 1'b1, 32'h0000_0000,
          32'h0000_0000},
        '{tea_pkg::ACT_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
        '{tea_pkg::ACT_DECRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
        '{tea_pkg::ACT_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{tea_pkg::ACT_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
        '{tea_pkg::ACT_ENCRYPT, 32'h0000_0001, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
        '{tea_pkg::ACT_DECRYPT, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, 32'h0, 32'h0},
        '{tea_pkg::ACT_ENCRYPT, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, 32'h0, 32'h0},
        '{tea_pkg::ACT_ENCRYPT, 32'h0000_0000, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
        '{tea_pkg::ACT_DECRYPT, 32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        '{tea_pkg::ACT_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef, 1'b0, 32'h0, 32'h0}
    };

    logic clk;
    logic rst_n;

    tea_in_if  blk_if ();
    tea_out_if res_if ();
    tea_cfg_if cfg_if ();

    tea_block_cipher #(
        .ROUNDS (NUM_ROUNDS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .blk   (blk_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    logic [tea_pkg::WORD_W-1:0] key_shadow [tea_pkg::KEY_WORDS];
    logic [63:0]                pending_blocks [$];
    int                         errors;
    bit                         no_gaps;
    bit                         stall_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [tea_pkg::WORD_W-1:0] half_round(
        input logic [tea_pkg::WORD_W-1:0] v,
        input logic [tea_pkg::WORD_W-1:0] s,
        input logic [tea_pkg::WORD_W-1:0] ka,
        input logic [tea_pkg::WORD_W-1:0] kb
    );
        logic [tea_pkg::WORD_W-1:0] up;
        logic [tea_pkg::WORD_W-1:0] dn;
        up = {v[tea_pkg::WORD_W-5:0], 4'b0000} + ka;
        dn = {5'b00000, v[tea_pkg::WORD_W-1:5]} + kb;
        return up ^ (v + s) ^ dn;
    endfunction

    function automatic logic [63:0] tea_cipher(
        input logic                       act,
        input logic [tea_pkg::WORD_W-1:0] y_in,
        input logic [tea_pkg::WORD_W-1:0] z_in
    );
        logic [tea_pkg::WORD_W-1:0] y;
        logic [tea_pkg::WORD_W-1:0] z;
        logic [tea_pkg::WORD_W-1:0] sum;
        y = y_in;
        z = z_in;
        if (act == tea_pkg::ACT_ENCRYPT)
        begin
            sum = '0;
            for (int r = 0; r < NUM_ROUNDS; r++)
            begin
                sum = sum + tea_pkg::DELTA;
                y   = y + half_round(z, sum, key_shadow[0], key_shadow[1]);
                z   = z + half_round(y, sum, key_shadow[2], key_shadow[3]);
            end
        end
        else
        begin
            sum = tea_pkg::DELTA * NUM_ROUNDS;
            for (int r = 0; r < NUM_ROUNDS; r++)
            begin
                z   = z - half_round(y, sum, key_shadow[2], key_shadow[3]);
                y   = y - half_round(z, sum, key_shadow[0], key_shadow[1]);
                sum = sum - tea_pkg::DELTA;
            end
        end
        return {y, z};
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what,
                                   input logic [tea_pkg::WORD_W-1:0] got,
                                   input logic [tea_pkg::WORD_W-1:0] want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_blocks.size() == 0)
                report_mismatch("unexpected result item", res_if.out_first_word, '0);
            else
            begin
                want = pending_blocks.pop_front();
                if (res_if.out_first_word !== want[63:32])
                    report_mismatch("out_first_word", res_if.out_first_word, want[63:32]);
                if (res_if.out_second_word !== want[31:0])
                    report_mismatch("out_second_word", res_if.out_second_word, want[31:0]);
            end
        end
    end

    // ---------------------------------------------------------------- result side

    initial
    begin
        bit stall_done;
        stall_done   = 1'b0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request && !stall_done)
            begin
                // long back-pressure: pipeline fills and blk must stall
                res_if.ready = 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
                stall_done = 1'b1;
            end
            res_if.ready = no_gaps ? 1'b1 : ($urandom_range(99) >= GAP_PERCENT);
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic drive_block(input logic act, input logic [tea_pkg::WORD_W-1:0] fw,
                               input logic [tea_pkg::WORD_W-1:0] sw, input bit typed,
                               input logic [63:0] typed_res);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < GAP_PERCENT)
        begin
            blk_if.valid = 1'b0;
            @(negedge clk);
        end
        blk_if.valid       = 1'b1;
        blk_if.action      = act;
        blk_if.first_word  = fw;
        blk_if.second_word = sw;
        do
            @(posedge clk);
        while (!blk_if.ready);
        pending_blocks.push_back(typed ? typed_res : tea_cipher(act, fw, sw));
    endtask

    task automatic write_reg(input logic [tea_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [tea_pkg::WORD_W-1:0] value);
        @(negedge clk);
        blk_if.valid = 1'b0;
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        if (idx < tea_pkg::KEY_WORDS)
            key_shadow[idx[1:0]] = value;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        blk_if.valid = 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [tea_pkg::WORD_W-1:0] pick_word();
        int k;
        k = $urandom_range(31);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << k;
            3:       return ~(32'h1 << k);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [tea_pkg::WORD_W-1:0] phase_key(input int phase, input int word);
        case (phase)
            0:       return '1;
            1:       return (word % 2 == 0) ? 32'h8000_0000 : 32'h0000_0001;
            2:       return (word % 2 == 0) ? 32'haaaa_aaaa : 32'h5555_5555;
            default: return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus

    initial
    begin
        logic [63:0] last_cipher;
        logic        act;
        errors             = 0;
        no_gaps            = 1'b0;
        stall_request      = 1'b0;
        last_cipher        = '0;
        rst_n              = 1'b0;
        blk_if.valid       = 1'b0;
        blk_if.action      = tea_pkg::ACT_ENCRYPT;
        blk_if.first_word  = '0;
        blk_if.second_word = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = tea_pkg::KEY_WORD_0_IDX;
        cfg_if.data        = '0;
        for (int i = 0; i < tea_pkg::KEY_WORDS; i++)
            key_shadow[i] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero key straight out of reset
        for (int i = 0; i < NUM_DIRECTED; i++)
            drive_block(DIRECTED[i].action, DIRECTED[i].first_word, DIRECTED[i].second_word,
                        DIRECTED[i].known, {DIRECTED[i].known_first, DIRECTED[i].known_second});
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(($urandom_range(1) == 0) ? UNUSED_IDX_LO : UNUSED_IDX_HI, $urandom);
            write_reg(tea_pkg::KEY_WORD_0_IDX, phase_key(p, 0));
            write_reg(tea_pkg::KEY_WORD_1_IDX, phase_key(p, 1));
            write_reg(tea_pkg::KEY_WORD_2_IDX, phase_key(p, 2));
            write_reg(tea_pkg::KEY_WORD_3_IDX, phase_key(p, 3));
            write_reg(3'(UNUSED_IDX_LO + $urandom_range(3)), $urandom);

            no_gaps       = (p == QUIET_PHASE);
            stall_request = (p == QUIET_PHASE);
            for (int n = 0; n < PHASE_BLOCKS; n++)
            begin
                // some decrypts of the previous ciphertext to exercise round trips
                if ($urandom_range(4) == 0)
                    drive_block(tea_pkg::ACT_DECRYPT, last_cipher[63:32], last_cipher[31:0],
                                1'b0, '0);
                else
                begin
                    act = $urandom_range(1) ? tea_pkg::ACT_DECRYPT : tea_pkg::ACT_ENCRYPT;
                    drive_block(act, pick_word(), pick_word(), 1'b0, '0);
                    if (act == tea_pkg::ACT_ENCRYPT)
                        last_cipher = pending_blocks[$];
                end
            end
            wait_drained();
            no_gaps = 1'b0;
        end

        repeat (2 * NUM_ROUNDS + 10) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
